### rtl/core/rmeu_pkg.sv
// Package of the execute unit: opcodes, instruction classes and the types
// that pass between the front, the back and the top level. No dependencies.
`default_nettype none
package rmeu_pkg;

	localparam logic [5:0] OP_MOV_RI  = 6'd0;
	localparam logic [5:0] OP_MOV_RR  = 6'd1;
	localparam logic [5:0] OP_LDR_ABS = 6'd2;
	localparam logic [5:0] OP_LDR_IDX = 6'd6;
	localparam logic [5:0] OP_STR_ABS = 6'd10;
	localparam logic [5:0] OP_STR_IDX = 6'd14;
	localparam logic [5:0] OP_ADD_RI  = 6'd18;
	localparam logic [5:0] OP_XOR_RR  = 6'd29;
	localparam logic [5:0] OP_NOT     = 6'd30;
	localparam logic [5:0] OP_SHR_RI  = 6'd31;
	localparam logic [5:0] OP_SHR_RR  = 6'd32;
	localparam logic [5:0] OP_SHL_RI  = 6'd33;
	localparam logic [5:0] OP_SHL_RR  = 6'd34;
	localparam logic [5:0] OP_CMP_RI  = 6'd35;
	localparam logic [5:0] OP_CMP_RR  = 6'd36;
	localparam logic [5:0] OP_JMP     = 6'd37;
	localparam logic [5:0] OP_JGE     = 6'd43;
	localparam logic [5:0] OP_SETE    = 6'd44;
	localparam logic [5:0] OP_SETNE   = 6'd45;

	localparam logic [3:0] CL_FAIL  = 4'd0;
	localparam logic [3:0] CL_BAD   = 4'd1;
	localparam logic [3:0] CL_ALU   = 4'd2;
	localparam logic [3:0] CL_LOAD  = 4'd3;
	localparam logic [3:0] CL_STORE = 4'd4;
	localparam logic [3:0] CL_SHR   = 4'd5;
	localparam logic [3:0] CL_SHL   = 4'd6;
	localparam logic [3:0] CL_CMP   = 4'd7;
	localparam logic [3:0] CL_JMP   = 4'd8;
	localparam logic [3:0] CL_SET   = 4'd9;

	localparam logic [2:0] ALU_ADD  = 3'd0;
	localparam logic [2:0] ALU_SUB  = 3'd1;
	localparam logic [2:0] ALU_MUL  = 3'd2;
	localparam logic [2:0] ALU_AND  = 3'd3;
	localparam logic [2:0] ALU_OR   = 3'd4;
	localparam logic [2:0] ALU_XOR  = 3'd5;
	localparam logic [2:0] ALU_PASS = 3'd6;
	localparam logic [2:0] ALU_NOT  = 3'd7;

	localparam logic [1:0] OPB_IMM  = 2'd0;
	localparam logic [1:0] OPB_REGA = 2'd1;
	localparam logic [1:0] OPB_REGB = 2'd2;

	localparam logic [2:0] JC_ALWAYS = 3'd0;
	localparam logic [2:0] JC_EQ     = 3'd1;
	localparam logic [2:0] JC_NE     = 3'd2;
	localparam logic [2:0] JC_LT     = 3'd3;
	localparam logic [2:0] JC_LE     = 3'd4;
	localparam logic [2:0] JC_GT     = 3'd5;
	localparam logic [2:0] JC_GE     = 3'd6;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_DECODE   = 2'd1;
	localparam logic [1:0] ST_UNSUPP   = 2'd2;
	localparam logic [1:0] ST_SHIFTBIG = 2'd3;

	localparam int REG_SLOTS = 16;

	typedef struct packed {
		logic [3:0]  cls;
		logic [2:0]  aluop;
		logic [1:0]  opb;
		logic [1:0]  size;
		logic        idx;
		logic [2:0]  cond;
		logic [3:0]  dest_reg;
		logic [3:0]  src_reg_a;
		logic [3:0]  src_reg_b;
		logic [31:0] immediate;
		logic        scale_enable;
		logic [1:0]  scale_shift;
		logic        base_enable;
		logic [31:0] displacement;
		logic [3:0]  length;
	} entry_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] next_ip;
		logic [2:0]  compare_flags;
		logic [63:0] dest_value;
	} result_t;

endpackage
`default_nettype wire

### rtl/core/rmeu_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module rmeu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### rtl/core/rmeu_front.sv
// Front part: accepts instruction beats, classifies them and holds them in a
// two entry queue for the back part. Depends on rmeu_pkg.
`default_nettype none
module rmeu_front
	import rmeu_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire logic   [5:0] command,
	input  wire entry_t in_fields,
	input  wire logic   hold,
	output logic        q_valid,
	output entry_t      q_entry,
	input  wire logic   q_pop
);
	entry_t      q_mem [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	entry_t      cls_e;

	always_comb begin
		cls_e = in_fields;
		cls_e.cls = CL_BAD;
		cls_e.aluop = ALU_PASS;
		cls_e.opb = OPB_IMM;
		cls_e.size = 2'd0;
		cls_e.idx = 1'b0;
		cls_e.cond = JC_ALWAYS;
		priority if (in_fields.length == 4'd0) begin
			cls_e.cls = CL_FAIL;
		end else if (command == OP_MOV_RI) begin
			cls_e.cls = CL_ALU;
		end else if (command == OP_MOV_RR) begin
			cls_e.cls = CL_ALU;
			cls_e.opb = OPB_REGA;
		end else if (command < OP_LDR_IDX) begin
			cls_e.cls = CL_LOAD;
			cls_e.size = 2'(command - OP_LDR_ABS);
		end else if (command < OP_STR_ABS) begin
			cls_e.cls = CL_LOAD;
			cls_e.idx = 1'b1;
			cls_e.size = 2'(command - OP_LDR_IDX);
		end else if (command < OP_STR_IDX) begin
			cls_e.cls = CL_STORE;
			cls_e.size = 2'(command - OP_STR_ABS);
		end else if (command < OP_ADD_RI) begin
			cls_e.cls = CL_STORE;
			cls_e.idx = 1'b1;
			cls_e.size = 2'(command - OP_STR_IDX);
		end else if (command <= OP_XOR_RR) begin
			cls_e.cls = CL_ALU;
			cls_e.aluop = 3'((command - OP_ADD_RI) >> 1);
			cls_e.opb = command[0] ? OPB_REGB : OPB_IMM;
		end else if (command == OP_NOT) begin
			cls_e.cls = CL_ALU;
			cls_e.aluop = ALU_NOT;
		end else if (command == OP_SHR_RI) begin
			cls_e.cls = CL_SHR;
		end else if (command == OP_SHR_RR) begin
			cls_e.cls = CL_SHR;
			cls_e.opb = OPB_REGB;
		end else if (command == OP_SHL_RI) begin
			cls_e.cls = CL_SHL;
		end else if (command == OP_SHL_RR) begin
			cls_e.cls = CL_SHL;
			cls_e.opb = OPB_REGB;
		end else if (command == OP_CMP_RI) begin
			cls_e.cls = CL_CMP;
		end else if (command == OP_CMP_RR) begin
			cls_e.cls = CL_CMP;
			cls_e.opb = OPB_REGA;
		end else if (command <= OP_JGE) begin
			cls_e.cls = CL_JMP;
			cls_e.cond = 3'(command - OP_JMP);
		end else if (command == OP_SETE) begin
			cls_e.cls = CL_SET;
			cls_e.cond = JC_EQ;
		end else if (command == OP_SETNE) begin
			cls_e.cls = CL_SET;
			cls_e.cond = JC_NE;
		end else begin
			cls_e.cls = CL_BAD;
		end
	end

	assign in_ready = !hold && (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_entry  = q_mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wptr_q] <= cls_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (q_pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

### rtl/core/rmeu_back.sv
// Back part: reads registers, executes, accesses the banked data memory and
// writes back. Depends on rmeu_pkg and rmeu_ram.
`default_nettype none
module rmeu_back
	import rmeu_pkg::*;
#(
	parameter int MEM_BYTES = 65536,
	parameter int NUM_REGS  = 16,
	parameter int IP_INDEX  = 15
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   q_valid,
	input  wire entry_t q_entry,
	output logic        q_pop,
	input  wire logic   out_free,
	output logic        res_valid,
	output result_t     res,
	output logic        clearing
);
	localparam int ADDR_W = $clog2(MEM_BYTES);
	localparam int ROWS   = MEM_BYTES / 8;
	localparam int ROW_W  = ADDR_W - 3;

	localparam logic [1:0] ST_READ = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]  state_q;
	entry_t      ex_q;
	logic [63:0] ip_q;
	logic [2:0]  flags_q;
	logic [REG_SLOTS-1:0] vld_q;
	logic        clr_q;
	logic [ROW_W-1:0] clr_row_q;

	logic [63:0] ra_data, rb_data, rd_data;
	logic [63:0] a_v, b_v, d_v, imm64, y_v, alu_v;
	logic        shift_big, take, reg_wen, exec_go, done_go;
	logic [1:0]  status_v;
	logic [2:0]  flags_v;
	logic [63:0] ip_adv;
	logic [31:0] ix_addr;
	logic [ADDR_W-1:0] addr;
	logic [ROW_W-1:0]  row, row_nx;
	logic [2:0]  lo;

	logic [63:0] alu_s2, ll_s2, d_s2, ipnew_s2;
	logic [31:0] lh_s2, hl_s2;
	logic [1:0]  status_s2;
	logic        wen_s2;
	logic [2:0]  lo_s2;
	logic [63:0] bank_word, ld_raw, ld_v, mul_v, wb_v, ip_fin, dest_fin;
	logic [127:0] rot_word;
	logic        dest_ok;

	logic [7:0]       bank_rdata [8];
	logic [ROW_W-1:0] bank_addr  [8];
	logic [ROW_W-1:0] bank_waddr [8];
	logic [7:0]       bank_wdata [8];
	logic             bank_we    [8];
	logic             bank_re;

	function automatic logic reg_ok(input logic [3:0] i);
		return ({1'b0, i} < 5'(NUM_REGS)) || (i == 4'(IP_INDEX));
	endfunction

	function automatic logic [63:0] rd_reg(input logic [3:0] i, input logic [63:0] ram,
			input logic [REG_SLOTS-1:0] vld, input logic [63:0] ip);
		logic [63:0] v;
		v = 64'd0;
		if (i == 4'(IP_INDEX)) begin
			v = ip;
		end else if (reg_ok(i) && vld[i]) begin
			v = ram;
		end
		return v;
	endfunction

	assign clearing = clr_q;
	assign q_pop    = (state_q == ST_READ) && q_valid && !clr_q;
	assign exec_go  = state_q == ST_EXEC;
	assign done_go  = (state_q == ST_DONE) && out_free;

	rmeu_ram #(.WIDTH(64), .DEPTH(REG_SLOTS)) u_rf_a (
		.clk(clk), .we(reg_wen), .waddr(ex_q.dest_reg), .wdata(wb_v),
		.re(q_pop), .raddr(q_entry.src_reg_a), .rdata(ra_data)
	);
	rmeu_ram #(.WIDTH(64), .DEPTH(REG_SLOTS)) u_rf_b (
		.clk(clk), .we(reg_wen), .waddr(ex_q.dest_reg), .wdata(wb_v),
		.re(q_pop), .raddr(q_entry.src_reg_b), .rdata(rb_data)
	);
	rmeu_ram #(.WIDTH(64), .DEPTH(REG_SLOTS)) u_rf_d (
		.clk(clk), .we(reg_wen), .waddr(ex_q.dest_reg), .wdata(wb_v),
		.re(q_pop), .raddr(q_entry.dest_reg), .rdata(rd_data)
	);

	always_comb begin
		a_v = rd_reg(ex_q.src_reg_a, ra_data, vld_q, ip_q);
		b_v = rd_reg(ex_q.src_reg_b, rb_data, vld_q, ip_q);
		d_v = rd_reg(ex_q.dest_reg, rd_data, vld_q, ip_q);
		imm64 = {{32{ex_q.immediate[31]}}, ex_q.immediate};
		unique case (ex_q.opb)
			OPB_REGA: y_v = a_v;
			OPB_REGB: y_v = b_v;
			default:  y_v = imm64;
		endcase
		shift_big = y_v[63:6] != 58'd0;
		alu_v = 64'd0;
		unique case (ex_q.cls)
			CL_ALU: begin
				unique case (ex_q.aluop)
					ALU_ADD:  alu_v = a_v + y_v;
					ALU_SUB:  alu_v = a_v - y_v;
					ALU_AND:  alu_v = a_v & y_v;
					ALU_OR:   alu_v = a_v | y_v;
					ALU_XOR:  alu_v = a_v ^ y_v;
					ALU_NOT:  alu_v = ~a_v;
					ALU_PASS: alu_v = y_v;
					default:  alu_v = 64'd0;
				endcase
			end
			CL_SHR: alu_v = shift_big ? 64'd0 : (a_v >> y_v[5:0]);
			CL_SHL: alu_v = shift_big ? 64'd0 : (a_v << y_v[5:0]);
			default: alu_v = 64'd0;
		endcase
		unique case (ex_q.cond)
			JC_ALWAYS: take = 1'b1;
			JC_EQ:     take = flags_q[0];
			JC_NE:     take = !flags_q[0];
			JC_LT:     take = flags_q[1];
			JC_LE:     take = flags_q[1] | flags_q[0];
			JC_GT:     take = flags_q[2];
			JC_GE:     take = flags_q[2] | flags_q[0];
			default:   take = 1'b0;
		endcase
		if (ex_q.cls == CL_SET) begin
			alu_v = {63'd0, take};
		end
		flags_v = {d_v > y_v, d_v < y_v, d_v == y_v};
		status_v = ST_OK;
		priority if (ex_q.cls == CL_FAIL) begin
			status_v = ST_DECODE;
		end else if (ex_q.cls == CL_BAD) begin
			status_v = ST_UNSUPP;
		end else if (ex_q.cls == CL_SHL && ex_q.opb == OPB_IMM && shift_big) begin
			status_v = ST_SHIFTBIG;
		end else begin
			status_v = ST_OK;
		end
		ip_adv = ip_q + {60'd0, ex_q.length};
		if (ex_q.cls == CL_FAIL) begin
			ip_adv = ip_q;
		end else if (ex_q.cls == CL_JMP && take) begin
			ip_adv = ip_q + {60'd0, ex_q.length} + imm64;
		end
		ix_addr = (ex_q.scale_enable ? (a_v[31:0] << ex_q.scale_shift) : 32'd0)
			+ (ex_q.base_enable ? b_v[31:0] : 32'd0) + ex_q.displacement;
		addr   = ex_q.idx ? ix_addr[ADDR_W-1:0] : ex_q.immediate[ADDR_W-1:0];
		lo     = addr[2:0];
		row    = addr[ADDR_W-1:3];
		row_nx = row + 1'b1;
	end

	assign bank_re = exec_go && (ex_q.cls == CL_LOAD);

	for (genvar j = 0; j < 8; j++) begin : g_bank
		logic [2:0] k;
		assign k = 3'(j) - lo;
		assign bank_addr[j]  = (3'(j) < lo) ? row_nx : row;
		assign bank_waddr[j] = clr_q ? clr_row_q : bank_addr[j];
		assign bank_wdata[j] = clr_q ? 8'd0 : d_v[8*k +: 8];
		assign bank_we[j]    = clr_q || (exec_go && (ex_q.cls == CL_STORE)
			&& ({1'b0, k} < (4'd1 << ex_q.size)));
		assign bank_word[8*j +: 8] = bank_rdata[j];
		rmeu_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
			.clk(clk), .we(bank_we[j]), .waddr(bank_waddr[j]), .wdata(bank_wdata[j]),
			.re(bank_re), .raddr(bank_addr[j]), .rdata(bank_rdata[j])
		);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ex_q <= q_entry;
		end
		if (exec_go) begin
			alu_s2    <= alu_v;
			ll_s2     <= 64'(a_v[31:0] * y_v[31:0]);
			lh_s2     <= 32'(a_v[31:0] * y_v[63:32]);
			hl_s2     <= 32'(a_v[63:32] * y_v[31:0]);
			d_s2      <= d_v;
			ipnew_s2  <= ip_adv;
			status_s2 <= status_v;
			lo_s2     <= lo;
			wen_s2    <= (status_v == ST_OK) && (ex_q.cls == CL_ALU || ex_q.cls == CL_SHR
				|| ex_q.cls == CL_SHL || ex_q.cls == CL_LOAD || ex_q.cls == CL_SET);
		end
	end

	always_comb begin
		rot_word = {bank_word, bank_word} >> {lo_s2, 3'b000};
		ld_raw   = rot_word[63:0];
		unique case (ex_q.size)
			2'd0:    ld_v = {56'd0, ld_raw[7:0]};
			2'd1:    ld_v = {48'd0, ld_raw[15:0]};
			2'd2:    ld_v = {32'd0, ld_raw[31:0]};
			default: ld_v = ld_raw;
		endcase
		mul_v = ll_s2 + {lh_s2 + hl_s2, 32'd0};
		if (ex_q.cls == CL_LOAD) begin
			wb_v = ld_v;
		end else if (ex_q.cls == CL_ALU && ex_q.aluop == ALU_MUL) begin
			wb_v = mul_v;
		end else begin
			wb_v = alu_s2;
		end
		dest_ok = reg_ok(ex_q.dest_reg);
		ip_fin  = (wen_s2 && ex_q.dest_reg == 4'(IP_INDEX)) ? wb_v : ipnew_s2;
		if (ex_q.dest_reg == 4'(IP_INDEX)) begin
			dest_fin = ip_fin;
		end else if (wen_s2 && dest_ok) begin
			dest_fin = wb_v;
		end else begin
			dest_fin = d_s2;
		end
		reg_wen = done_go && wen_s2 && dest_ok && (ex_q.dest_reg != 4'(IP_INDEX));
	end

	assign res_valid         = done_go;
	assign res.status        = status_s2;
	assign res.next_ip       = ip_fin;
	assign res.compare_flags = flags_q;
	assign res.dest_value    = dest_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_READ;
			ip_q      <= 64'd0;
			flags_q   <= 3'd0;
			vld_q     <= '0;
			clr_q     <= 1'b1;
			clr_row_q <= '0;
		end else begin
			if (clr_q) begin
				clr_row_q <= clr_row_q + 1'b1;
				if (clr_row_q == ROW_W'(ROWS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_READ: begin
					if (q_pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (ex_q.cls == CL_CMP) begin
						flags_q <= flags_v;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (done_go) begin
						ip_q <= ip_fin;
						if (reg_wen) begin
							vld_q[ex_q.dest_reg] <= 1'b1;
						end
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_READ;
			endcase
		end
	end

	a_wb_in_done: assert property (@(posedge clk) disable iff (!arst_n)
		reg_wen |-> state_q == ST_DONE)
		else $error("register write outside write-back");
	a_store_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_we[0] && !clr_q) |-> state_q == ST_EXEC)
		else $error("memory write outside execute");
	a_pop_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == ST_EXEC)
		else $error("popped instruction did not enter execute");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !q_pop)
		else $error("instruction issued during memory clear");
endmodule
`default_nettype wire

### rtl/core/register_machine_execute_unit.sv
// Top level of the execute unit: front queue, back part and output register.
// Depends on rmeu_pkg, rmeu_front and rmeu_back.
//
// Each instruction beat yields one result beat. The back part steps through
// register file read, execute with memory access and write-back for each
// instruction and pops the next one only after write-back; the front queue
// of two entries and the output register keep both sides decoupled. After
// reset the data memory is cleared one 8-byte row per cycle, during which
// s_tready is low. MEM_BYTES must be a power of two.
`default_nettype none
module register_machine_execute_unit
	import rmeu_pkg::*;
#(
	parameter int MEM_BYTES = 65536,
	parameter int NUM_REGS  = 16,
	parameter int IP_INDEX  = 15
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// command, dest_reg, src_reg_a, src_reg_b, immediate, scale_enable,
	// scale_shift, base_enable, displacement, length, zero fill
	input  wire logic [95:0]  s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status, next_ip, compare_flags, dest_value, zero fill
	output logic      [135:0] m_tdata
);
	entry_t  in_e;
	entry_t  q_entry;
	logic    q_valid, q_pop, clearing, out_free, res_valid;
	result_t res;
	result_t out_q;
	logic    out_vld_q;

	always_comb begin
		in_e = '0;
		in_e.dest_reg     = s_tdata[9:6];
		in_e.src_reg_a    = s_tdata[13:10];
		in_e.src_reg_b    = s_tdata[17:14];
		in_e.immediate    = s_tdata[49:18];
		in_e.scale_enable = s_tdata[50];
		in_e.scale_shift  = s_tdata[52:51];
		in_e.base_enable  = s_tdata[53];
		in_e.displacement = s_tdata[85:54];
		in_e.length       = s_tdata[89:86];
	end

	rmeu_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.command(s_tdata[5:0]), .in_fields(in_e), .hold(clearing),
		.q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop)
	);

	rmeu_back #(.MEM_BYTES(MEM_BYTES), .NUM_REGS(NUM_REGS), .IP_INDEX(IP_INDEX)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_entry(q_entry), .q_pop(q_pop),
		.out_free(out_free), .res_valid(res_valid), .res(res), .clearing(clearing)
	);

	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= res_valid;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'd0, out_q.dest_value, out_q.compare_flags, out_q.next_ip,
		out_q.status};
endmodule
`default_nettype wire

### tb/register_machine_execute_unit_tb.sv
// Testbench of the execute unit: directed table then random instructions,
// each result beat checked against a behavioral model. Depends on rmeu_pkg and register_machine_execute_unit.
`timescale 1ns / 1ps
module register_machine_execute_unit_tb;
	import rmeu_pkg::*;

	localparam int MEMB = 65536;
	localparam int LIMIT = 1000000;
	localparam logic [5:0] OP_STR64_IDX = 6'd17;
	localparam logic [5:0] OP_LDR64_IDX = 6'd9;
	localparam logic [5:0] OP_UNUSED = 6'd63;

	typedef struct {
		logic [5:0]  cmd;
		logic [3:0]  rd, ra, rb;
		logic [31:0] imm;
		logic        sen;
		logic [1:0]  ssh;
		logic        ben;
		logic [31:0] disp;
		logic [3:0]  len;
	} instr_t;

	typedef struct {
		logic        known;
		result_t     res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [135:0] m_tdata;

	logic [63:0] regs [16];
	logic [7:0]  mem [MEMB];
	logic [2:0]  flags;
	result_t     pending [$];
	int          errors = 0;
	int          cycles = 0;
	bit          sending_done = 1'b0;
	bit          hold_long = 1'b0;

	register_machine_execute_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [95:0] pack_instr(instr_t i);
		return {6'd0, i.len, i.disp, i.ben, i.ssh, i.sen, i.imm, i.rb, i.ra, i.rd, i.cmd};
	endfunction

	function automatic logic [63:0] load_bytes(logic [31:0] addr, int n);
		logic [63:0] v;
		v = '0;
		for (int k = 0; k < n; k++)
			v[8*k +: 8] = mem[(addr + k) % MEMB];
		return v;
	endfunction

	function automatic result_t execute_instr(instr_t i);
		result_t r;
		logic [63:0] imm, disp, a, b, d, ix, y, alu;
		logic [31:0] absa, ixa;
		int nb;
		bit take;
		logic [5:0] op;
		op = i.cmd;
		imm = {{32{i.imm[31]}}, i.imm};
		disp = {{32{i.disp[31]}}, i.disp};
		r.status = ST_OK;
		if (i.len == 0) begin
			r.status = ST_DECODE;
		end else begin
			a = regs[i.ra];
			b = regs[i.rb];
			d = regs[i.rd];
			absa = i.imm % MEMB;
			ix = (i.sen ? (a << i.ssh) : 64'd0) + (i.ben ? b : 64'd0) + disp;
			ixa = ix[31:0] % MEMB;
			regs[15] = regs[15] + i.len;
			nb = 1 << (op[1:0] ^ 2'd2);
			if (op == OP_MOV_RI) begin
				regs[i.rd] = imm;
			end else if (op == OP_MOV_RR) begin
				regs[i.rd] = a;
			end else if (op < OP_LDR_IDX) begin
				regs[i.rd] = load_bytes(absa, nb);
			end else if (op < OP_STR_ABS) begin
				regs[i.rd] = load_bytes(ixa, nb);
			end else if (op < OP_ADD_RI) begin
				for (int k = 0; k < nb; k++)
					mem[((op < OP_STR_IDX ? absa : ixa) + k) % MEMB] = d[8*k +: 8];
			end else if (op <= OP_XOR_RR) begin
				y = op[0] ? b : imm;
				case ((op - OP_ADD_RI) >> 1)
					0: alu = a + y;
					1: alu = a - y;
					2: alu = a * y;
					3: alu = a & y;
					4: alu = a | y;
					default: alu = a ^ y;
				endcase
				regs[i.rd] = alu;
			end else if (op == OP_NOT) begin
				regs[i.rd] = ~a;
			end else if (op == OP_SHR_RI) begin
				regs[i.rd] = imm >= 64 ? 64'd0 : a >> imm[5:0];
			end else if (op == OP_SHR_RR) begin
				regs[i.rd] = b >= 64 ? 64'd0 : a >> b[5:0];
			end else if (op == OP_SHL_RI) begin
				if (imm >= 64) r.status = ST_SHIFTBIG;
				else regs[i.rd] = a << imm[5:0];
			end else if (op == OP_SHL_RR) begin
				regs[i.rd] = b >= 64 ? 64'd0 : a << b[5:0];
			end else if (op == OP_CMP_RI || op == OP_CMP_RR) begin
				y = (op == OP_CMP_RI) ? imm : a;
				flags = {d > y, d < y, d == y};
			end else if (op <= OP_JGE) begin
				case (op - OP_JMP)
					0: take = 1;
					1: take = flags[0];
					2: take = !flags[0];
					3: take = flags[1];
					4: take = flags[1] | flags[0];
					5: take = flags[2];
					default: take = flags[2] | flags[0];
				endcase
				if (take) regs[15] = regs[15] + imm;
			end else if (op == OP_SETE) begin
				regs[i.rd] = {63'd0, flags[0]};
			end else if (op == OP_SETNE) begin
				regs[i.rd] = {63'd0, !flags[0]};
			end else begin
				r.status = ST_UNSUPP;
			end
		end
		r.next_ip = regs[15];
		r.compare_flags = flags;
		r.dest_value = regs[i.rd];
		return r;
	endfunction

	function automatic instr_t mk(logic [5:0] c, logic [3:0] rd, logic [3:0] ra, logic [3:0] rb,
			logic [31:0] imm, logic [31:0] disp, logic [3:0] len);
		instr_t i;
		i.cmd = c; i.rd = rd; i.ra = ra; i.rb = rb; i.imm = imm;
		i.sen = 1'b1; i.ssh = 2'd3; i.ben = 1'b1; i.disp = disp; i.len = len;
		return i;
	endfunction

	function automatic instr_t random_instr();
		instr_t i;
		i.cmd = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(46, 63)) : 6'($urandom_range(0, 45));
		i.rd = 4'($urandom); i.ra = 4'($urandom); i.rb = 4'($urandom);
		case ($urandom_range(0, 3))
			0: i.imm = $urandom;
			1: i.imm = $urandom_range(0, 70);
			2: i.imm = -$urandom_range(0, 70);
			default: i.imm = $urandom_range(0, MEMB - 1);
		endcase
		i.sen = 1'($urandom); i.ssh = 2'($urandom); i.ben = 1'($urandom);
		i.disp = ($urandom_range(0, 1)) ? $urandom : 32'($urandom_range(0, 300));
		i.len = ($urandom_range(0, 19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
		if (i.len == 1 && $urandom_range(0, 3) == 0) i.len = 4'd15;
		return i;
	endfunction

	task automatic send(instr_t i);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 2) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_instr(i);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending.push_back(execute_instr(i));
	endtask

	row_t   dir_known [$];
	instr_t dir_instr [$];

	initial begin
		instr_t t;
		row_t k;
		result_t ex;
		for (int n = 0; n < 16; n++) regs[n] = '0;
		for (int n = 0; n < MEMB; n++) mem[n] = '0;
		flags = '0;
		// Directed rows: the first few have results written out by hand.
		t = mk(6'd0, 4'd0, 4'd0, 4'd0, 32'd0, 32'd0, 4'd0);
		k.known = 1; k.res = '{ST_DECODE, 64'd0, 3'd0, 64'd0};
		dir_instr.push_back(t); dir_known.push_back(k);
		t = mk(OP_UNUSED, 4'd3, 4'd0, 4'd0, 32'd0, 32'd0, 4'd15);
		k.res = '{ST_UNSUPP, 64'd15, 3'd0, 64'd0};
		dir_instr.push_back(t); dir_known.push_back(k);
		t = mk(OP_SHL_RI, 4'd2, 4'd0, 4'd0, 32'hFFFF_FFFF, 32'd0, 4'd1);
		k.res = '{ST_SHIFTBIG, 64'd16, 3'd0, 64'd0};
		dir_instr.push_back(t); dir_known.push_back(k);
		t = mk(OP_MOV_RI, 4'd1, 4'd0, 4'd0, 32'h8000_0000, 32'd0, 4'd1);
		k.res = '{ST_OK, 64'd17, 3'd0, 64'hFFFF_FFFF_8000_0000};
		dir_instr.push_back(t); dir_known.push_back(k);
		k.known = 0;
		dir_instr.push_back(mk(OP_MOV_RI, 4'd2, 0, 0, 32'h7FFF_FFFF, 0, 4'd2));
		dir_instr.push_back(mk(OP_MOV_RI, 4'd4, 0, 0, 32'hFFFF_F000, 0, 4'd2));
		dir_instr.push_back(mk(OP_STR64_IDX, 4'd1, 4'd4, 4'd2, 0, 32'hFFFF_FFFD, 4'd3));
		dir_instr.push_back(mk(OP_LDR64_IDX, 4'd5, 4'd4, 4'd2, 0, 32'hFFFF_FFFD, 4'd3));
		dir_instr.push_back(mk(OP_STR_ABS + 3, 4'd2, 0, 0, 32'hFFFF_FFFE, 0, 4'd4));
		dir_instr.push_back(mk(OP_LDR_ABS + 1, 4'd6, 0, 0, 32'h0000_FFFF, 0, 4'd4));
		dir_instr.push_back(mk(OP_LDR_ABS, 4'd7, 0, 0, 32'h0001_FFFE, 0, 4'd4));
		dir_instr.push_back(mk(6'd22, 4'd8, 4'd1, 0, 32'hFFFF_FFFF, 0, 4'd5));
		dir_instr.push_back(mk(OP_NOT, 4'd9, 4'd0, 0, 0, 0, 4'd5));
		dir_instr.push_back(mk(OP_SHR_RI, 4'd10, 4'd9, 0, 32'd64, 0, 4'd6));
		dir_instr.push_back(mk(OP_SHR_RI, 4'd10, 4'd9, 0, 32'd63, 0, 4'd6));
		dir_instr.push_back(mk(OP_SHR_RR, 4'd11, 4'd9, 4'd9, 0, 0, 4'd6));
		dir_instr.push_back(mk(OP_SHL_RI, 4'd12, 4'd9, 0, 32'd63, 0, 4'd6));
		dir_instr.push_back(mk(OP_SHL_RR, 4'd12, 4'd9, 4'd10, 0, 0, 4'd6));
		dir_instr.push_back(mk(OP_CMP_RR, 4'd1, 4'd2, 0, 0, 0, 4'd7));
		dir_instr.push_back(mk(6'd40, 0, 0, 0, 32'd100, 0, 4'd7));
		dir_instr.push_back(mk(OP_SETNE, 4'd13, 0, 0, 0, 0, 4'd7));
		dir_instr.push_back(mk(OP_CMP_RI, 4'd2, 0, 0, 32'h7FFF_FFFF, 0, 4'd8));
		dir_instr.push_back(mk(6'd38, 0, 0, 0, 32'hFFFF_FF00, 0, 4'd8));
		dir_instr.push_back(mk(OP_SETE, 4'd14, 0, 0, 0, 0, 4'd8));
		dir_instr.push_back(mk(OP_JMP, 4'd15, 0, 0, 32'h8000_0000, 0, 4'd15));
		while (dir_known.size() < dir_instr.size()) dir_known.push_back(k);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_instr[n]) begin
			send(dir_instr[n]);
			if (dir_known[n].known) begin
				ex = pending[$];
				if (ex != dir_known[n].res) begin
					$error("row %0d: table value %h, model %h", n, dir_known[n].res, ex);
					errors++;
				end
			end
		end
		for (int n = 0; n < 500; n++) begin
			if (n == 200) hold_long = 1'b1;
			send(random_instr());
		end
		s_tvalid <= 1'b0;
		sending_done = 1'b1;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				m_tready <= 1'b0;
				repeat (60) @(posedge clk);
			end
			stall = $urandom_range(0, 9);
			m_tready <= (stall < 6) || (stall == 9 && $urandom_range(0, 1) == 0);
		end
	end

	always @(posedge clk) begin
		result_t got, ex;
		if (m_tvalid && m_tready) begin
			got.status        = m_tdata[1:0];
			got.next_ip       = m_tdata[65:2];
			got.compare_flags = m_tdata[68:66];
			got.dest_value    = m_tdata[132:69];
			if (pending.size() == 0) begin
				$error("result beat with no instruction outstanding");
				errors++;
			end else begin
				ex = pending.pop_front();
				if (got.status != ex.status) begin
					$error("status: expected %0d, actual %0d", ex.status, got.status);
					errors++;
				end
				if (got.next_ip != ex.next_ip) begin
					$error("next_ip: expected %h, actual %h", ex.next_ip, got.next_ip);
					errors++;
				end
				if (got.compare_flags != ex.compare_flags) begin
					$error("compare_flags: expected %b, actual %b", ex.compare_flags,
						got.compare_flags);
					errors++;
				end
				if (got.dest_value != ex.dest_value) begin
					$error("dest_value: expected %h, actual %h", ex.dest_value, got.dest_value);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (sending_done);
		while (pending.size() != 0 && cycles < LIMIT) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending.size() == 0)
			$display("register_machine_execute_unit: match");
		else
			$display("register_machine_execute_unit: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT + 100) begin
			$display("register_machine_execute_unit: mismatch");
			$finish;
		end
	end

endmodule
